[rtl/core/tses_pkg.sv]
// ----------------------------------------------------------------------------
// tses_pkg: shared definitions for the envelope shaper
// Request kinds, register indexes, filter modes, default sizes and the
// reset curve of the point table.
// ----------------------------------------------------------------------------
package tses_pkg;

    localparam int MAX_POINTS_DEF  = 16;
    localparam int COEFF_DEPTH_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int MUL_A_BITS      = 40;
    localparam int MUL_B_BITS_DEF  = SAMPLE_BITS_DEF + 2;

    localparam int Q16_BITS        = 17;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [16:0] SMOOTH_LIN_MAX = 17'd655;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_COEFF  = 2'd2,
        KIND_PHASE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_GAIN = 2'd0,
        MODE_HP   = 2'd1,
        MODE_BP   = 2'd2,
        MODE_LP   = 2'd3
    } t_mode;

    localparam logic [2:0] REG_MIX    = 3'd0;
    localparam logic [2:0] REG_SMOOTH = 3'd1;
    localparam logic [2:0] REG_MODE   = 3'd2;
    localparam logic [2:0] REG_ENABLE = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;
    localparam logic [2:0] REG_STEP   = 3'd5;

    function automatic logic [16:0] dip_point(input int unsigned idx);
        logic [16:0] v;
        unique case (idx)
            0: v = 17'd65536;
            1: v = 17'd0;
            2: v = 17'd3277;
            3: v = 17'd13107;
            4: v = 17'd39322;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/tempo_synced_envelope_shaper.sv]
// ----------------------------------------------------------------------------
// tempo_synced_envelope_shaper: phase-driven envelope gain and filter
// A small sequencer steps one shared multiplier through the envelope,
// the one-pole filters or the gain, and the dry/wet mix for every enabled stereo sample.
// ----------------------------------------------------------------------------
// A write-point, write-coefficient or set-phase request is taken and the
// block is ready again at once. A sample request holds the block busy
// while the sequencer drives the single shared multiplier, one product
// per cycle: it forms a linear or a spline envelope, then the gain, or the
// high-, low- or band-pass filter and the mix, and hands the result to the
// output register. A bypassed sample goes straight to the output
// register. The output register lets the next request be accepted while a
// result still waits to be taken.
module tempo_synced_envelope_shaper #(
    parameter int MAX_POINTS  = tses_pkg::MAX_POINTS_DEF,
    parameter int COEFF_DEPTH = tses_pkg::COEFF_DEPTH_DEF,
    parameter int SAMPLE_BITS = tses_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [tses_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [tses_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_kind,
    input  logic signed [SAMPLE_BITS-1:0]        i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]        i_right_in,
    input  logic [7:0]                           i_entry_index,
    input  logic [31:0]                          i_entry_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]        o_left_out,
    output logic signed [SAMPLE_BITS-1:0]        o_right_out
);

    localparam int S   = SAMPLE_BITS;
    localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = $clog2(COEFF_DEPTH);
    localparam int AW  = tses_pkg::MUL_A_BITS;
    localparam int BW  = SAMPLE_BITS + 2;
    localparam int PW  = AW + BW;

    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [4:0] {
        S_IDLE, S_SEG, S_T, S_R0, S_R1, S_R2, S_R3, S_R4,
        S_C1, S_C2, S_C3, S_C4, S_C5,
        S_G1, S_G2, S_G3, S_G4, S_G5,
        S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
        S_X1, S_X2, S_X3, S_X4, S_X5, S_FIN
    } t_state;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                 input int unsigned sh);
        logic signed [PW-1:0] bias;
        bias = PW'(1) <<< (sh - 1);
        return (v + bias) >>> sh;
    endfunction

    function automatic logic [S-1:0] sat(input logic signed [PW-1:0] v);
        logic [S-1:0] o;
        if (v > SAT_HI) begin
            o = SAT_HI[S-1:0];
        end else if (v < SAT_LO) begin
            o = SAT_LO[S-1:0];
        end else begin
            o = v[S-1:0];
        end
        return o;
    endfunction

    t_state                r_state;
    logic [16:0]           r_mix, r_smooth;
    logic [1:0]            r_mode;
    logic                  r_en;
    logic [4:0]            r_pcnt;
    logic [31:0]           r_step, r_phase;
    logic signed [S-1:0]   r_lowl, r_lowr, r_bandl, r_bandr;
    logic signed [S-1:0]   r_l, r_r, r_res_l, r_res_r;
    logic                  r_adv;
    logic                  r_out_valid;
    logic signed [S-1:0]   r_out_l, r_out_r;

    logic [NW-1:0]         r_seg;
    logic [15:0]           r_t, r_t2, r_t3;
    logic [16:0]           r_p0, r_p1, r_p2, r_p3;
    logic [32:0]           r_lin;
    logic signed [AW-1:0]  r_sum;
    logic signed [PW-1:0]  r_acc;
    logic [16:0]           r_env;
    logic [32:0]           r_g;
    logic [CW-1:0]         r_ci;

    logic [16:0]           pt_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_pt_valid;
    logic [PAW-1:0]        r_pt_addr;
    logic [16:0]           r_pt_rd;
    logic [16:0]           co_mem [COEFF_DEPTH];
    logic [16:0]           r_co_rd;

    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PW-1:0]  mul_p;

    logic                  in_acc;
    logic [31:0]           idx_w;
    logic [16:0]           val_c;
    logic                  pt_we, co_we;
    logic [16:0]           mix_c, s_c, one_m_mix, one_m_s;
    logic [NW-1:0]         n_pts, seg_raw, n_seg, i0, i2, i3;
    logic [32:0]           n_lin, lin_env;
    logic signed [20:0]    q0, q1, q2, q3, c1, c2, d21, d20;
    logic signed [S:0]     wl_l, wl_r, dl, dr, dbl, dbr;
    logic signed [PW-1:0]  env_val, ci_val, pole_sum, mix_out, gain_out;
    logic signed [S-1:0]   pole_st;
    logic [16:0]           env_c;
    logic [CW-1:0]         ci_c;

    tses_mul #(
        .A_BITS (AW),
        .B_BITS (BW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

    assign idx_w = 32'(i_entry_index);
    assign val_c = (i_entry_value > 32'd65536) ? tses_pkg::ONE_Q16 : i_entry_value[16:0];
    assign pt_we = in_acc && (i_kind == tses_pkg::KIND_POINT) && (idx_w < 32'(MAX_POINTS));
    assign co_we = in_acc && (i_kind == tses_pkg::KIND_COEFF) && (idx_w < 32'(COEFF_DEPTH));

    always_comb begin
        mix_c     = (r_mix > tses_pkg::ONE_Q16) ? tses_pkg::ONE_Q16 : r_mix;
        s_c       = (r_smooth > tses_pkg::ONE_Q16) ? tses_pkg::ONE_Q16 : r_smooth;
        one_m_mix = tses_pkg::ONE_Q16 - mix_c;
        one_m_s   = tses_pkg::ONE_Q16 - s_c;
        if (r_pcnt < 5'd2) begin
            n_pts = NW'(2);
        end else if (32'(r_pcnt) > 32'(MAX_POINTS)) begin
            n_pts = NW'(MAX_POINTS);
        end else begin
            n_pts = NW'(r_pcnt);
        end
        seg_raw = mul_p[32 +: NW];
        n_seg   = (seg_raw > n_pts - NW'(2)) ? n_pts - NW'(2) : seg_raw;
        i0      = (r_seg != '0) ? r_seg - NW'(1) : '0;
        i2      = r_seg + NW'(1);
        i3      = (r_seg + NW'(2) > n_pts - NW'(1)) ? n_pts - NW'(1) : r_seg + NW'(2);
        n_lin   = {r_p1, 16'b0} + mul_p[32:0];
        lin_env = n_lin + 33'd32768;

        q0  = $signed({4'b0, r_p0});
        q1  = $signed({4'b0, r_p1});
        q2  = $signed({4'b0, r_p2});
        q3  = $signed({4'b0, r_p3});
        c1  = (q0 <<< 1) - ((q1 <<< 2) + q1) + (q2 <<< 2) - q3;
        c2  = (q1 <<< 1) + q1 - q0 - ((q2 <<< 1) + q2) + q3;
        d21 = q2 - q1;
        d20 = q2 - q0;

        dl  = (S+1)'(r_l) - (S+1)'(r_lowl);
        dr  = (S+1)'(r_r) - (S+1)'(r_lowr);
        dbl = (S+1)'(r_lowl) - (S+1)'(r_bandl);
        dbr = (S+1)'(r_lowr) - (S+1)'(r_bandr);
        unique case (r_mode)
            tses_pkg::MODE_HP: begin
                wl_l = dl;
                wl_r = dr;
            end
            tses_pkg::MODE_BP: begin
                wl_l = dbl;
                wl_r = dbr;
            end
            default: begin
                wl_l = (S+1)'(r_lowl);
                wl_r = (S+1)'(r_lowr);
            end
        endcase

        env_val = rnd(r_acc + mul_p, 33);
        if (env_val < 0) begin
            env_c = '0;
        end else if (env_val > PW'(tses_pkg::ONE_Q16)) begin
            env_c = tses_pkg::ONE_Q16;
        end else begin
            env_c = env_val[16:0];
        end
        ci_val = rnd(mul_p, 16);
        if (ci_val < 0) begin
            ci_c = '0;
        end else if (ci_val > PW'(COEFF_DEPTH - 1)) begin
            ci_c = CW'(COEFF_DEPTH - 1);
        end else begin
            ci_c = ci_val[CW-1:0];
        end

        unique case (r_state)
            S_F5:    pole_st = r_lowl;
            S_F6:    pole_st = r_lowr;
            S_F7:    pole_st = r_bandl;
            default: pole_st = r_bandr;
        endcase
        pole_sum = PW'(pole_st) + rnd(mul_p, 16);
        mix_out  = rnd(r_acc + mul_p, 16);
        gain_out = rnd(mul_p, 32);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SEG: begin
                mul_a = AW'($signed({1'b0, r_phase}));
                mul_b = BW'($signed({1'b0, n_pts - NW'(1)}));
            end
            S_R0: begin
                mul_a = AW'($signed({1'b0, r_t}));
                mul_b = BW'($signed({1'b0, r_t}));
            end
            S_R2: begin
                mul_a = AW'($signed({1'b0, r_t2}));
                mul_b = BW'($signed({1'b0, r_t}));
            end
            S_R3: begin
                mul_a = AW'(d21);
                mul_b = BW'($signed({1'b0, r_t}));
            end
            S_R4: begin
                mul_a = AW'(d20);
                mul_b = BW'($signed({1'b0, r_t}));
            end
            S_C1: begin
                mul_a = AW'(c1);
                mul_b = BW'($signed({1'b0, r_t2}));
            end
            S_C2: begin
                mul_a = AW'(c2);
                mul_b = BW'($signed({1'b0, r_t3}));
            end
            S_C3: begin
                mul_a = AW'($signed({1'b0, r_lin, 1'b0}));
                mul_b = BW'($signed({1'b0, one_m_s}));
            end
            S_C4: begin
                mul_a = r_sum;
                mul_b = BW'($signed({1'b0, s_c}));
            end
            S_G1: begin
                mul_a = AW'($signed({1'b0, r_env}));
                mul_b = BW'($signed({1'b0, mix_c}));
            end
            S_G3: begin
                mul_a = AW'($signed({1'b0, r_g}));
                mul_b = BW'(r_l);
            end
            S_G4: begin
                mul_a = AW'($signed({1'b0, r_g}));
                mul_b = BW'(r_r);
            end
            S_F1: begin
                mul_a = AW'($signed({1'b0, r_env}));
                mul_b = BW'(COEFF_DEPTH - 1);
            end
            S_F4: begin
                mul_a = AW'($signed({1'b0, r_co_rd}));
                mul_b = BW'(dl);
            end
            S_F5: begin
                mul_a = AW'($signed({1'b0, r_co_rd}));
                mul_b = BW'(dr);
            end
            S_F6: begin
                mul_a = AW'($signed({1'b0, r_co_rd}));
                mul_b = BW'(dbl);
            end
            S_F7: begin
                mul_a = AW'($signed({1'b0, r_co_rd}));
                mul_b = BW'(dbr);
            end
            S_X1: begin
                mul_a = AW'(r_l);
                mul_b = BW'($signed({1'b0, one_m_mix}));
            end
            S_X2: begin
                mul_a = AW'(wl_l);
                mul_b = BW'($signed({1'b0, mix_c}));
            end
            S_X3: begin
                mul_a = AW'(r_r);
                mul_b = BW'($signed({1'b0, one_m_mix}));
            end
            S_X4: begin
                mul_a = AW'(wl_r);
                mul_b = BW'($signed({1'b0, mix_c}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[idx_w[PAW-1:0]] <= val_c;
        end
        r_pt_rd <= r_pt_valid[r_pt_addr] ? pt_mem[r_pt_addr]
                                         : tses_pkg::dip_point(32'(r_pt_addr));
    end

    always_ff @(posedge i_clk) begin
        if (co_we) begin
            co_mem[idx_w[CW-1:0]] <= val_c;
        end
        r_co_rd <= co_mem[r_ci];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mix       <= tses_pkg::ONE_Q16;
            r_smooth    <= 17'd19661;
            r_mode      <= tses_pkg::MODE_GAIN;
            r_en        <= 1'b1;
            r_pcnt      <= 5'd6;
            r_step      <= 32'd1;
            r_phase     <= '0;
            r_lowl      <= '0;
            r_lowr      <= '0;
            r_bandl     <= '0;
            r_bandr     <= '0;
            r_pt_valid  <= '0;
            r_out_valid <= 1'b0;
            r_adv       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    tses_pkg::REG_MIX:    r_mix    <= i_cfg_data[16:0];
                    tses_pkg::REG_SMOOTH: r_smooth <= i_cfg_data[16:0];
                    tses_pkg::REG_MODE:   r_mode   <= i_cfg_data[1:0];
                    tses_pkg::REG_ENABLE: r_en     <= i_cfg_data[0];
                    tses_pkg::REG_COUNT:  r_pcnt   <= i_cfg_data[4:0];
                    tses_pkg::REG_STEP:   r_step   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (pt_we) begin
                r_pt_valid[idx_w[PAW-1:0]] <= 1'b1;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_kind)
                            tses_pkg::KIND_SAMPLE: begin
                                r_l     <= i_left_in;
                                r_r     <= i_right_in;
                                r_res_l <= i_left_in;
                                r_res_r <= i_right_in;
                                r_adv   <= r_en;
                                r_state <= r_en ? S_SEG : S_FIN;
                            end
                            tses_pkg::KIND_PHASE: r_phase <= i_entry_value;
                            default: ;
                        endcase
                    end
                end
                S_SEG: r_state <= S_T;
                S_T: begin
                    r_seg     <= n_seg;
                    r_t       <= mul_p[31:16];
                    r_pt_addr <= n_seg[PAW-1:0];
                    r_state   <= S_R0;
                end
                S_R0: begin
                    r_pt_addr <= i2[PAW-1:0];
                    r_state   <= S_R1;
                end
                S_R1: begin
                    r_p1      <= r_pt_rd;
                    r_t2      <= mul_p[31:16];
                    r_pt_addr <= i0[PAW-1:0];
                    r_state   <= S_R2;
                end
                S_R2: begin
                    r_p2      <= r_pt_rd;
                    r_pt_addr <= i3[PAW-1:0];
                    r_state   <= S_R3;
                end
                S_R3: begin
                    r_p0    <= r_pt_rd;
                    r_t3    <= mul_p[31:16];
                    r_state <= S_R4;
                end
                S_R4: begin
                    r_p3  <= r_pt_rd;
                    r_lin <= n_lin;
                    if (s_c <= tses_pkg::SMOOTH_LIN_MAX) begin
                        r_env   <= lin_env[32:16];
                        r_state <= (r_mode == tses_pkg::MODE_GAIN) ? S_G1 : S_F1;
                    end else begin
                        r_state <= S_C1;
                    end
                end
                S_C1: begin
                    r_sum   <= AW'($signed({1'b0, r_p1, 17'b0})) + AW'(mul_p);
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_sum   <= r_sum + AW'(mul_p);
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_sum   <= r_sum + AW'(mul_p);
                    r_state <= S_C4;
                end
                S_C4: begin
                    r_acc   <= mul_p;
                    r_state <= S_C5;
                end
                S_C5: begin
                    r_env   <= env_c;
                    r_state <= (r_mode == tses_pkg::MODE_GAIN) ? S_G1 : S_F1;
                end
                S_G1: r_state <= S_G2;
                S_G2: begin
                    r_g     <= {one_m_mix, 16'b0} + mul_p[32:0];
                    r_state <= S_G3;
                end
                S_G3: r_state <= S_G4;
                S_G4: begin
                    r_res_l <= sat(gain_out);
                    r_state <= S_G5;
                end
                S_G5: begin
                    r_res_r <= sat(gain_out);
                    r_state <= S_FIN;
                end
                S_F1: r_state <= S_F2;
                S_F2: begin
                    r_ci    <= ci_c;
                    r_state <= S_F3;
                end
                S_F3: r_state <= S_F4;
                S_F4: r_state <= S_F5;
                S_F5: begin
                    r_lowl  <= pole_sum[S-1:0];
                    r_state <= S_F6;
                end
                S_F6: begin
                    r_lowr  <= pole_sum[S-1:0];
                    r_state <= (r_mode == tses_pkg::MODE_BP) ? S_F7 : S_X1;
                end
                S_F7: begin
                    r_bandl <= pole_sum[S-1:0];
                    r_state <= S_F8;
                end
                S_F8: begin
                    r_bandr <= pole_sum[S-1:0];
                    r_state <= S_X1;
                end
                S_X1: r_state <= S_X2;
                S_X2: begin
                    r_acc   <= mul_p;
                    r_state <= S_X3;
                end
                S_X3: begin
                    r_res_l <= sat(mix_out);
                    r_state <= S_X4;
                end
                S_X4: begin
                    r_acc   <= mul_p;
                    r_state <= S_X5;
                end
                S_X5: begin
                    r_res_r <= sat(mix_out);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_l     <= r_res_l;
                        r_out_r     <= r_res_r;
                        if (r_adv) begin
                            r_phase <= r_phase + r_step;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/tses_mul.sv]
// ----------------------------------------------------------------------------
// tses_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module tses_mul #(
    parameter int A_BITS = tses_pkg::MUL_A_BITS,
    parameter int B_BITS = tses_pkg::MUL_B_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic signed [A_BITS-1:0]         i_a,
    input  logic signed [B_BITS-1:0]         i_b,
    output logic signed [A_BITS+B_BITS-1:0]  o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule
